// ===== hw/rtl/mlfd_pkg.sv =====
// Shared types and constants for the marker/length frame deframer.
// No dependencies; used by mlfd_core and the top level.
package mlfd_pkg;

    localparam int unsigned WordWidth   = 32;
    localparam int unsigned LengthWidth = 10;
    localparam int unsigned ByteWidth   = 8;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HEAD_MARKER = 2'd0;
    localparam logic [1:0] CFG_TAIL_MARKER = 2'd1;
    localparam logic [1:0] CFG_MAX_LENGTH  = 2'd2;

    // Register reset values.
    localparam logic [WordWidth-1:0]   HEAD_MARKER_RESET = 32'h0000_0101;
    localparam logic [WordWidth-1:0]   TAIL_MARKER_RESET = 32'h0000_0202;
    localparam logic [LengthWidth-1:0] MAX_LENGTH_RESET  = 10'd1008;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BADTAIL = 2'd2,
        KIND_TOOLONG = 2'd3
    } kind_t;

    // One result item as produced by the core for an accepted byte.
    typedef struct packed {
        logic                   valid;
        kind_t                  kind;
        logic [ByteWidth-1:0]   data;
        logic [LengthWidth-1:0] length;
        logic                   last;
    } result_t;

endpackage

// ===== hw/rtl/marker_length_frame_deframer_unit.sv =====
// Top level of the marker/length frame deframer: configuration registers,
// the parsing core and the registered result channel.
// Depends on mlfd_pkg and mlfd_core.

// The deframer takes one received byte per cycle and recovers frames made of
// a big-endian head marker, type word, length word, payload and tail marker.
// Every accepted byte is handled in the cycle it is accepted and its result,
// if any, appears in the output register on the next cycle, so the sustained
// rate is one byte per cycle; s_ready drops only while a held result is not
// taken. Payload bytes come out with kind 0, and each frame ends with one
// status transfer (good, tail mismatch, or length too large) with m_out_last
// set. Lengths above the smaller of max_length and BUFFER_BYTES - 16 are
// rejected, and after any error the block hunts for the head marker again,
// one byte at a time. Configuration writes are always ready and should be
// issued while no frame is in progress.
module marker_length_frame_deframer_unit #(
    parameter int unsigned BUFFER_BYTES = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [mlfd_pkg::WordWidth-1:0]      cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [mlfd_pkg::ByteWidth-1:0]      s_rx_byte,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_out_kind,
    output logic signed [mlfd_pkg::WordWidth-1:0] m_out_type,
    output logic [mlfd_pkg::ByteWidth-1:0]      m_out_byte,
    output logic [mlfd_pkg::LengthWidth-1:0]    m_out_length,
    output logic                                m_out_last
);

    logic [mlfd_pkg::WordWidth-1:0]     head_marker_reg;
    logic [mlfd_pkg::WordWidth-1:0]     tail_marker_reg;
    logic [mlfd_pkg::LengthWidth-1:0]   max_length_reg;

    logic                               m_valid_reg;
    mlfd_pkg::kind_t                    kind_reg;
    logic [mlfd_pkg::WordWidth-1:0]     type_reg;
    logic [mlfd_pkg::ByteWidth-1:0]     byte_reg;
    logic [mlfd_pkg::LengthWidth-1:0]   length_reg;
    logic                               last_reg;

    logic                               accept;
    mlfd_pkg::result_t                  result;
    logic [mlfd_pkg::WordWidth-1:0]     frame_type;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_marker_reg <= mlfd_pkg::HEAD_MARKER_RESET;
            tail_marker_reg <= mlfd_pkg::TAIL_MARKER_RESET;
            max_length_reg  <= mlfd_pkg::MAX_LENGTH_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                mlfd_pkg::CFG_HEAD_MARKER: head_marker_reg <= cfg_data;
                mlfd_pkg::CFG_TAIL_MARKER: tail_marker_reg <= cfg_data;
                mlfd_pkg::CFG_MAX_LENGTH:  max_length_reg  <= cfg_data[mlfd_pkg::LengthWidth-1:0];
                default: ;
            endcase
        end
    end

    mlfd_core #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .rx_byte     (s_rx_byte),
        .head_marker (head_marker_reg),
        .tail_marker (tail_marker_reg),
        .max_length  (max_length_reg),
        .result      (result),
        .frame_type  (frame_type)
    );

    // The output register is loaded whenever the accepted byte yields a result;
    // s_ready guarantees any held result has been transferred by then.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && result.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && result.valid) begin
            kind_reg   <= result.kind;
            type_reg   <= frame_type;
            byte_reg   <= result.data;
            length_reg <= result.length;
            last_reg   <= result.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_kind   = kind_reg;
    assign m_out_type   = type_reg;
    assign m_out_byte   = byte_reg;
    assign m_out_length = length_reg;
    assign m_out_last   = last_reg;

endmodule

// ===== hw/rtl/mlfd_core.sv =====
// Frame parsing state machine of the deframer: word assembly, head marker
// hunt, type and length capture, payload counting and tail check.
// Depends on mlfd_pkg.
module mlfd_core #(
    parameter int unsigned BUFFER_BYTES = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                accept,
    input  logic [mlfd_pkg::ByteWidth-1:0]      rx_byte,
    input  logic [mlfd_pkg::WordWidth-1:0]      head_marker,
    input  logic [mlfd_pkg::WordWidth-1:0]      tail_marker,
    input  logic [mlfd_pkg::LengthWidth-1:0]    max_length,
    output mlfd_pkg::result_t                   result,
    output logic [mlfd_pkg::WordWidth-1:0]      frame_type
);

    localparam int unsigned BufferCap = (BUFFER_BYTES > 16) ? BUFFER_BYTES - 16 : 0;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_TYPE    = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_TAIL    = 3'd4
    } phase_t;

    phase_t                             phase_reg, phase_next;
    logic [mlfd_pkg::WordWidth-1:0]     word_shift_reg, word_shift_next;
    logic [1:0]                         word_bytes_reg, word_bytes_next;
    logic [mlfd_pkg::WordWidth-1:0]     frame_type_reg, frame_type_next;
    logic [mlfd_pkg::LengthWidth-1:0]   frame_length_reg, frame_length_next;
    logic [mlfd_pkg::LengthWidth-1:0]   payload_count_reg, payload_count_next;

    logic [mlfd_pkg::WordWidth-1:0]     shifted;
    logic [mlfd_pkg::LengthWidth-1:0]   count_inc;
    logic [mlfd_pkg::WordWidth-1:0]     length_limit;

    assign shifted   = {word_shift_reg[mlfd_pkg::WordWidth-mlfd_pkg::ByteWidth-1:0], rx_byte};
    assign count_inc = payload_count_reg + mlfd_pkg::LengthWidth'(1);
    assign length_limit = (32'(BufferCap) < 32'(max_length)) ? 32'(BufferCap)
                                                             : 32'(max_length);
    assign frame_type = frame_type_reg;

    always_comb begin
        phase_next         = phase_reg;
        word_shift_next    = word_shift_reg;
        word_bytes_next    = word_bytes_reg;
        frame_type_next    = frame_type_reg;
        frame_length_next  = frame_length_reg;
        payload_count_next = payload_count_reg;
        result             = '0;

        if (accept) begin
            if (phase_reg == PH_PAYLOAD) begin
                result.valid       = 1'b1;
                result.kind        = mlfd_pkg::KIND_DATA;
                result.data        = rx_byte;
                result.length      = frame_length_reg;
                payload_count_next = count_inc;
                if (count_inc >= frame_length_reg) begin
                    phase_next      = PH_TAIL;
                    word_shift_next = '0;
                    word_bytes_next = '0;
                end
            end else begin
                word_shift_next = shifted;
                if (word_bytes_reg != 2'd3) begin
                    word_bytes_next = word_bytes_reg + 2'd1;
                end else begin
                    case (phase_reg)
                        PH_TYPE: begin
                            frame_type_next = shifted;
                            phase_next      = PH_LEN;
                            word_shift_next = '0;
                            word_bytes_next = '0;
                        end
                        PH_LEN: begin
                            word_shift_next = '0;
                            word_bytes_next = '0;
                            if (shifted > length_limit) begin
                                result.valid = 1'b1;
                                result.kind  = mlfd_pkg::KIND_TOOLONG;
                                result.last  = 1'b1;
                                phase_next   = PH_HUNT;
                            end else begin
                                frame_length_next  = shifted[mlfd_pkg::LengthWidth-1:0];
                                payload_count_next = '0;
                                phase_next = (shifted[mlfd_pkg::LengthWidth-1:0] == '0)
                                             ? PH_TAIL : PH_PAYLOAD;
                            end
                        end
                        PH_TAIL: begin
                            result.valid    = 1'b1;
                            result.kind     = (shifted == tail_marker)
                                              ? mlfd_pkg::KIND_GOOD : mlfd_pkg::KIND_BADTAIL;
                            result.length   = frame_length_reg;
                            result.last     = 1'b1;
                            phase_next      = PH_HUNT;
                            word_shift_next = '0;
                            word_bytes_next = '0;
                        end
                        default: begin
                            // Hunting: the window keeps sliding until it matches.
                            if (shifted == head_marker) begin
                                phase_next      = PH_TYPE;
                                word_shift_next = '0;
                                word_bytes_next = '0;
                            end else begin
                                phase_next = PH_HUNT;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HUNT;
            word_shift_reg    <= '0;
            word_bytes_reg    <= '0;
            frame_type_reg    <= '0;
            frame_length_reg  <= '0;
            payload_count_reg <= '0;
        end else begin
            phase_reg         <= phase_next;
            word_shift_reg    <= word_shift_next;
            word_bytes_reg    <= word_bytes_next;
            frame_type_reg    <= frame_type_next;
            frame_length_reg  <= frame_length_next;
            payload_count_reg <= payload_count_next;
        end
    end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for marker_length_frame_deframer_unit.
// Uses mlfd_pkg for kinds and register indexes. Sends directed and random byte streams,
// predicts every result in the bench, and checks each result transfer in order.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BufferBytes = 1024;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LEN,
        PH_PAYLOAD,
        PH_TAIL
    } deframe_phase_t;

    typedef struct {
        mlfd_pkg::kind_t kind;
        logic [31:0]     frame_type;
        logic [7:0]      data;
        logic [9:0]      length;
        logic            last;
    } frame_result_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = mlfd_pkg::CFG_HEAD_MARKER;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_out_kind;
    logic signed [31:0] m_out_type;
    logic [7:0]  m_out_byte;
    logic [9:0]  m_out_length;
    logic        m_out_last;

    // Bench copy of the configuration and of the parser state.
    logic [31:0]    head_word;
    logic [31:0]    tail_word;
    logic [9:0]     max_len;
    deframe_phase_t parse_phase;
    logic [31:0]    window;
    int             window_fill;
    logic [31:0]    cur_type;
    logic [9:0]     cur_length;
    logic [9:0]     payload_seen;

    frame_result_t pending_results[$];
    int            mismatches = 0;
    int            bytes_sent = 0;
    int            send_gap_pct = 0;
    int            recv_stall_pct = 0;

    marker_length_frame_deframer_unit #(
        .BUFFER_BYTES(BufferBytes)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_kind  (m_out_kind),
        .m_out_type  (m_out_type),
        .m_out_byte  (m_out_byte),
        .m_out_length(m_out_length),
        .m_out_last  (m_out_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int unsigned length_limit();
        int unsigned buf_limit;
        buf_limit = (BufferBytes > 16) ? BufferBytes - 16 : 0;
        return (buf_limit < max_len) ? buf_limit : max_len;
    endfunction

    function automatic void queue_result(mlfd_pkg::kind_t kind, logic [7:0] data,
                                         logic [9:0] length, logic last);
        frame_result_t r;
        r.kind       = kind;
        r.frame_type = cur_type;
        r.data       = data;
        r.length     = length;
        r.last       = last;
        pending_results.push_back(r);
    endfunction

    function automatic void restart_window(deframe_phase_t next_phase);
        parse_phase = next_phase;
        window      = '0;
        window_fill = 0;
    endfunction

    // Advances the bench parser by one accepted byte and queues its result, if any.
    function automatic void deframe_byte(logic [7:0] b);
        if (parse_phase == PH_PAYLOAD) begin
            queue_result(mlfd_pkg::KIND_DATA, b, cur_length, 1'b0);
            payload_seen = payload_seen + 10'd1;
            if (payload_seen >= cur_length) begin
                restart_window(PH_TAIL);
            end
            return;
        end
        window = {window[23:0], b};
        if (window_fill < 3) begin
            window_fill++;
            return;
        end
        case (parse_phase)
            PH_TYPE: begin
                cur_type = window;
                restart_window(PH_LEN);
            end
            PH_LEN: begin
                if (window > length_limit()) begin
                    queue_result(mlfd_pkg::KIND_TOOLONG, 8'h00, 10'd0, 1'b1);
                    restart_window(PH_HUNT);
                end else begin
                    cur_length   = window[9:0];
                    payload_seen = '0;
                    restart_window((cur_length == 0) ? PH_TAIL : PH_PAYLOAD);
                end
            end
            PH_TAIL: begin
                queue_result((window == tail_word) ? mlfd_pkg::KIND_GOOD
                                                   : mlfd_pkg::KIND_BADTAIL,
                             8'h00, cur_length, 1'b1);
                restart_window(PH_HUNT);
            end
            default: begin
                // While hunting, the window keeps sliding until the head marker shows up.
                if (window == head_word) begin
                    restart_window(PH_TYPE);
                end else begin
                    parse_phase = PH_HUNT;
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result expected none, actual kind %0d type %h byte %h len %0d",
                         $time, m_out_kind, m_out_type, m_out_byte, m_out_length);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("out_kind", want.kind, m_out_kind);
                check_field("out_type", want.frame_type, m_out_type);
                check_field("out_byte", want.data, m_out_byte);
                check_field("out_length", want.length, m_out_length);
                check_field("out_last", want.last, m_out_last);
            end
        end
    end

    // Sends one byte, with a random number of idle cycles ahead of it.
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) begin
            push_byte(w[8*i +: 8]);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Holds cfg_valid high for one transfer; the caller lowers it after the last one.
    task automatic put_reg(input logic [1:0] index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            mlfd_pkg::CFG_HEAD_MARKER: head_word = value;
            mlfd_pkg::CFG_TAIL_MARKER: tail_word = value;
            mlfd_pkg::CFG_MAX_LENGTH:  max_len = value[9:0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [31:0] head, input logic [31:0] tail,
                                input logic [9:0] max_length);
        put_reg(mlfd_pkg::CFG_HEAD_MARKER, head);
        put_reg(mlfd_pkg::CFG_TAIL_MARKER, tail);
        put_reg(mlfd_pkg::CFG_MAX_LENGTH, {22'd0, max_length});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_length();
        int unsigned lim;
        int unsigned sel;
        lim = length_limit();
        sel = $urandom_range(99);
        if (lim == 0 || sel < 10) return 0;
        if (sel < 18) return (lim <= 64) ? lim : $urandom_range(13, 64);
        return $urandom_range(1, (lim < 12) ? lim : 12);
    endfunction

    task automatic push_junk(input int count);
        for (int i = 0; i < count; i++) begin
            push_byte($urandom_range(255));
        end
    endtask

    task automatic push_random_frame();
        int unsigned sel;
        logic [31:0] length;
        logic [31:0] tail;
        sel = $urandom_range(99);
        if (sel < 70) begin
            push_junk($urandom_range(3));
            push_word(head_word);
            push_word($urandom);
            length = pick_length();
            push_word(length);
            push_junk(length);
            tail = tail_word;
            if ($urandom_range(99) < 15) tail[$urandom_range(31)] ^= 1'b1;
            push_word(tail);
        end else if (sel < 82) begin
            push_junk($urandom_range(3));
            push_word(head_word);
            push_word($urandom);
            length = $urandom_range(1) ? length_limit() + 1 : $urandom;
            if (length <= length_limit()) length = length_limit() + 1;
            push_word(length);
        end else if (sel < 90) begin
            // A frame cut short: the following bytes get parsed as its fields.
            push_word(head_word);
            push_junk($urandom_range(6));
        end else begin
            push_junk($urandom_range(1, 12));
        end
    endtask

    task automatic test_directed_frames();
        send_gap_pct   = 36;
        recv_stall_pct = 86;
        // A stray byte first, so the head marker is found one byte further on.
        push_byte(8'h01);
        push_word(mlfd_pkg::HEAD_MARKER_RESET);
        push_word(32'h8000_0000);
        push_word(32'd2);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_word(mlfd_pkg::TAIL_MARKER_RESET);
        // Zero length with a bad tail that looks like a head marker; it must not
        // start a frame of its own.
        push_word(mlfd_pkg::HEAD_MARKER_RESET);
        push_word(32'h7FFF_FFFF);
        push_word(32'd0);
        push_word(mlfd_pkg::HEAD_MARKER_RESET);
        // One byte over the largest length.
        push_word(mlfd_pkg::HEAD_MARKER_RESET);
        push_word(32'hFFFF_FFFF);
        push_word(32'd1009);
    endtask

    task automatic test_random_frames(input logic [31:0] head, input logic [31:0] tail,
                                      input logic [9:0] max_length, input int gap_pct,
                                      input int stall_pct, input int budget);
        int target;
        drain_results();
        write_config(head, tail, max_length);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        target = bytes_sent + budget;
        while (bytes_sent < target) begin
            push_random_frame();
        end
    endtask

    initial begin
        head_word    = mlfd_pkg::HEAD_MARKER_RESET;
        tail_word    = mlfd_pkg::TAIL_MARKER_RESET;
        max_len      = mlfd_pkg::MAX_LENGTH_RESET;
        cur_type     = '0;
        cur_length   = '0;
        payload_seen = '0;
        restart_window(PH_HUNT);

        aresetn <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_frames();
        test_random_frames(32'hFFFF_FFFF, 32'h0000_0000, 10'd23, 36, 86, 450);
        test_random_frames(32'h0000_0000, 32'hFFFF_FFFF, 10'd0, 86, 36, 150);
        test_random_frames($urandom, $urandom, 10'd1008, 86, 36, 350);
        test_random_frames($urandom, $urandom, 10'($urandom_range(1, 64)), 0, 0, 450);

        drain_results();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mlfd_pkg.sv
hw/rtl/mlfd_core.sv
hw/rtl/marker_length_frame_deframer_unit.sv
tb/tb.sv
